// ----- hw/rtl/lrts_pkg.sv -----
// lrts_pkg: beat types and fixed field widths for the longest-remaining-time scheduler
// no dependencies; used by lrts_ctrl, lrts_dpath and the top level
package lrts_pkg;

  localparam int TASK_ID_W = 5;
  localparam int FIELD_W   = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [TASK_ID_W-1:0] task_id;
    logic [FIELD_W-1:0]   arrival_time;
    logic [FIELD_W-1:0]   burst_length;
  } in_item_t;

  typedef struct packed {
    logic                 error;
    logic                 ran_valid;
    logic [TASK_ID_W-1:0] ran_task;
    logic                 completed;
    logic [FIELD_W-1:0]   finish_time;
    logic [FIELD_W-1:0]   turnaround;
    logic [FIELD_W-1:0]   waiting;
    logic [FIELD_W-1:0]   current_time_out;
  } out_item_t;

  // one task table entry
  typedef struct packed {
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] remaining;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic dispatch;
    logic scan_start;
    logic scan_run;
    logic writeback;
    logic emit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_tick;
    logic time_sat;
    logic scan_done;
  } dp_stat_t;

endpackage

// ----- hw/rtl/lrts_ctrl.sv -----
// lrts_ctrl: sequencing state machine and output beat valid for the scheduler
// depends on lrts_pkg (ctl_cmd_t, dp_stat_t)
module lrts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lrts_pkg::dp_stat_t stat,
  output lrts_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_WB   = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd.dispatch = 1'b1;
        if (stat.op_tick && !stat.time_sat) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.writeback = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result emitted over a held beat");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_SCAN) |-> $past(state_r) == ST_DISP)
    else $error("scan entered without dispatch");

  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && stat.scan_done) |=> state_r == ST_WB)
    else $error("finished scan did not write back");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !(cmd.dispatch || cmd.scan_run || cmd.writeback))
    else $error("datapath command while idle");
`endif

endmodule

// ----- hw/rtl/lrts_dpath.sv -----
// lrts_dpath: task table memory, loaded bits, scheduler time, selection sweep, result regs
// depends on lrts_pkg (beat types, entry_t, command/status structs)
module lrts_dpath #(
  parameter int MAX_TASKS = 32,
  parameter int TIME_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lrts_pkg::in_item_t  in_data,
  output lrts_pkg::out_item_t out_data,
  input  lrts_pkg::ctl_cmd_t  cmd,
  output lrts_pkg::dp_stat_t  stat
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (TIME_BITS > lrts_pkg::FIELD_W) ? TIME_BITS : lrts_pkg::FIELD_W;
  localparam int FW    = lrts_pkg::FIELD_W;
  localparam int TID_W = lrts_pkg::TASK_ID_W;

  lrts_pkg::entry_t    mem [MAX_TASKS];
  lrts_pkg::in_item_t  item_r;
  lrts_pkg::out_item_t res_r, res_nxt;
  lrts_pkg::out_item_t out_r;
  lrts_pkg::entry_t    rd_data_r;
  lrts_pkg::entry_t    best_r;
  lrts_pkg::entry_t    wr_data;

  logic [MAX_TASKS-1:0] loaded_r;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     rd_idx_r, best_idx_r, wr_idx, slot_idx;
  logic                 best_valid_r;
  logic                 slot_ok, load_wr, wr_en, rd_en, cand, better;
  logic [FW-1:0]        rem_dec;
  logic [TIME_BITS-1:0] time_inc, tat, wt;

  assign slot_idx = IDX_W'(item_r.task_id);
  assign slot_ok  = 32'(item_r.task_id) < 32'(MAX_TASKS);
  assign load_wr  = cmd.dispatch && (item_r.operation == lrts_pkg::OP_LOAD)
                    && (item_r.burst_length != '0) && slot_ok;

  // sweep: read slot cnt, compare the slot read in the previous cycle
  assign rd_en = cmd.scan_run && (cnt_r < CNT_W'(MAX_TASKS));
  assign cand  = cmd.scan_run && (cnt_r != '0) && loaded_r[rd_idx_r]
                 && (rd_data_r.remaining != '0)
                 && (CMP_W'(rd_data_r.arrival) <= CMP_W'(time_r));
  assign better = !best_valid_r
                  || (rd_data_r.remaining > best_r.remaining)
                  || ((rd_data_r.remaining == best_r.remaining)
                      && (rd_data_r.arrival < best_r.arrival));

  assign time_inc = time_r + TIME_BITS'(1);
  assign rem_dec  = best_r.remaining - FW'(1);
  assign tat      = time_inc - TIME_BITS'(best_r.arrival);
  assign wt       = tat - TIME_BITS'(best_r.burst);

  // single write port shared by load and write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = slot_idx;
    wr_data = '{arrival: item_r.arrival_time, burst: item_r.burst_length,
                remaining: item_r.burst_length};
    if (load_wr) begin
      wr_en = 1'b1;
    end else if (cmd.writeback && best_valid_r) begin
      wr_en   = 1'b1;
      wr_idx  = best_idx_r;
      wr_data = '{arrival: best_r.arrival, burst: best_r.burst, remaining: rem_dec};
    end
  end

  always_comb begin
    time_nxt = time_r;
    res_nxt  = res_r;
    if (cmd.dispatch) begin
      res_nxt                  = '0;
      res_nxt.current_time_out = FW'(time_r);
      if (item_r.operation == lrts_pkg::OP_LOAD) begin
        res_nxt.error = (item_r.burst_length == '0);
      end else begin
        res_nxt.error = stat.time_sat;
      end
    end else if (cmd.writeback) begin
      time_nxt                 = time_inc;
      res_nxt                  = '0;
      res_nxt.current_time_out = FW'(time_inc);
      if (best_valid_r) begin
        res_nxt.ran_valid = 1'b1;
        res_nxt.ran_task  = TID_W'(best_idx_r);
        if (rem_dec == '0) begin
          res_nxt.completed   = 1'b1;
          res_nxt.finish_time = FW'(time_inc);
          res_nxt.turnaround  = FW'(tat);
          res_nxt.waiting     = FW'(wt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[cnt_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r       <= '0;
      loaded_r     <= '0;
      cnt_r        <= '0;
      best_valid_r <= 1'b0;
    end else begin
      time_r <= time_nxt;
      if (load_wr) begin
        loaded_r[wr_idx] <= 1'b1;
      end
      if (cmd.scan_start) begin
        cnt_r        <= '0;
        best_valid_r <= 1'b0;
      end else if (cmd.scan_run && !stat.scan_done) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cand && better) begin
        best_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item_r <= in_data;
    end
    if (rd_en) begin
      rd_idx_r <= cnt_r[IDX_W-1:0];
    end
    if (cand && better) begin
      best_r     <= rd_data_r;
      best_idx_r <= rd_idx_r;
    end
    res_r <= res_nxt;
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  assign stat.op_tick   = (item_r.operation == lrts_pkg::OP_TICK);
  assign stat.time_sat  = &time_r;
  assign stat.scan_done = (cnt_r == CNT_W'(MAX_TASKS));
  assign out_data       = out_r;

endmodule

// ----- hw/rtl/longest_remaining_time_scheduler_top.sv -----
// Longest-remaining-time-first scheduler: a task table of MAX_TASKS slots and a
// TIME_BITS scheduler clock. A load beat (operation 0) writes a slot's arrival
// time and burst and restarts its remaining time; a zero burst is refused with
// error set, and a slot number at or above MAX_TASKS is dropped silently. A tick
// beat (operation 1) runs for one unit the loaded, unfinished task that has
// arrived and has the most remaining time (ties: earlier arrival, then lower
// slot), advances time by one and, when the task finishes, reports finish,
// turnaround and waiting times. With nothing ready the tick is idle but time
// still moves; at the largest time value a tick only reports error. Every input
// beat gives exactly one result beat. A load passes through dispatch and emit; a
// tick below the largest time value also runs the selection sweep, which reads
// one task table entry per cycle through the table memory's single read port,
// and a write-back. A finished result sits in an output register, so the next
// beat is taken while it waits on out_stall. The task table itself has no
// reset; only its loaded bits are cleared.
// depends on lrts_pkg, lrts_ctrl, lrts_dpath
module longest_remaining_time_scheduler_top #(
  parameter int MAX_TASKS = 32,
  parameter int TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // input beats
  input  logic                in_valid,
  output logic                in_stall,
  input  lrts_pkg::in_item_t  in_data,
  // result beats
  output logic                out_valid,
  input  logic                out_stall,
  output lrts_pkg::out_item_t out_data
);

  // command and status between sequencer and datapath
  lrts_pkg::ctl_cmd_t cmd;
  lrts_pkg::dp_stat_t stat;

  // sequencer: accept, dispatch, sweep, write-back, emit
  lrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // task table, time counter, best-candidate tracking and result registers
  lrts_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ----- verif/tb_longest_remaining_time_scheduler_top.sv -----
// self-checking testbench for longest_remaining_time_scheduler_top: directed and random
// load/tick beats, a beat-level scheduler predictor and an in-order result scoreboard
// depends on lrts_pkg and longest_remaining_time_scheduler_top
module tb_longest_remaining_time_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS         = 32;
  localparam logic [15:0] TIME_MAX      = 16'hFFFF;
  localparam int          RESET_CYCLES  = 12;
  localparam int          RANDOM_BEATS  = 1250;
  localparam int          FAST_BEATS    = 40;
  // settle well past the length of a tick before the final verdict
  localparam int          SETTLE_CYCLES = 4 * (SLOTS + 5);
  // longest correct quiet stretch is a tick plus a sender gap plus a stall run,
  // and the limit is far above that
  localparam int          QUIET_LIMIT   = 2000;

  // scheduler predictor plus queue of expected result beats
  class sched_scoreboard;
    bit [15:0]   arrival   [SLOTS];
    bit [15:0]   burst     [SLOTS];
    bit [15:0]   remaining [SLOTS];
    bit          loaded    [SLOTS];
    bit [15:0]   now;
    lrts_pkg::out_item_t pending [$];
    int unsigned mismatches;
    int unsigned loads, refused, ticks, ran, completions, idle_ticks, saturated;

    function string show(lrts_pkg::out_item_t r);
      return $sformatf("err=%0d ran=%0d task=%0d done=%0d fin=%0d tat=%0d wt=%0d time=%0d",
                       r.error, r.ran_valid, r.ran_task, r.completed, r.finish_time,
                       r.turnaround, r.waiting, r.current_time_out);
    endfunction

    // apply one accepted input beat to the model and queue its result
    function void note_request(lrts_pkg::in_item_t beat);
      lrts_pkg::out_item_t want;
      int                  best;
      want = '0;
      if (beat.operation == lrts_pkg::OP_LOAD) begin
        loads++;
        if (beat.burst_length == '0) begin
          // zero burst is refused and the slot keeps its old contents
          want.error = 1'b1;
          refused++;
        end else begin
          arrival[beat.task_id]   = beat.arrival_time;
          burst[beat.task_id]     = beat.burst_length;
          remaining[beat.task_id] = beat.burst_length;
          loaded[beat.task_id]    = 1'b1;
        end
      end else if (now == TIME_MAX) begin
        // time saturated: tick does nothing but flag it
        want.error = 1'b1;
        ticks++;
        saturated++;
      end else begin
        ticks++;
        best = -1;
        for (int k = 0; k < SLOTS; k++) begin
          if (loaded[k] && remaining[k] != '0 && arrival[k] <= now &&
              (best < 0 || remaining[k] > remaining[best] ||
               (remaining[k] == remaining[best] && arrival[k] < arrival[best])))
            best = k;
        end
        now++;
        if (best < 0) begin
          idle_ticks++;
        end else begin
          ran++;
          want.ran_valid = 1'b1;
          want.ran_task  = best[4:0];
          remaining[best]--;
          if (remaining[best] == '0) begin
            completions++;
            want.completed   = 1'b1;
            want.finish_time = now;
            want.turnaround  = now - arrival[best];
            want.waiting     = want.turnaround - burst[best];
          end
        end
      end
      want.current_time_out = now;
      pending.push_back(want);
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_report(lrts_pkg::out_item_t got);
      lrts_pkg::out_item_t want;
      string               bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %s", show(got));
        return;
      end
      want = pending.pop_front();
      bad  = "";
      if (got.error !== want.error)                       bad = {bad, " error"};
      if (got.ran_valid !== want.ran_valid)               bad = {bad, " ran_valid"};
      if (got.ran_task !== want.ran_task)                 bad = {bad, " ran_task"};
      if (got.completed !== want.completed)               bad = {bad, " completed"};
      if (got.finish_time !== want.finish_time)           bad = {bad, " finish_time"};
      if (got.turnaround !== want.turnaround)             bad = {bad, " turnaround"};
      if (got.waiting !== want.waiting)                   bad = {bad, " waiting"};
      if (got.current_time_out !== want.current_time_out) bad = {bad, " current_time_out"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on%s\n  expected %s\n  actual   %s", bad, show(want), show(got));
      end
    endfunction
  endclass

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RARE, RX_RUNS} rx_mode_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lrts_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lrts_pkg::out_item_t out_data;

  sched_scoreboard sb;
  int unsigned     quiet_cycles = 0;
  int unsigned     beats_left   = 0;
  bit              sender_fast  = 1'b0;  // no sender gaps
  bit              rx_free      = 1'b0;  // receiver never stalls
  rx_mode_e        rx_mode      = RX_OPEN;
  int unsigned     rx_mode_left = 0;
  int unsigned     rx_run_left  = 0;

  longest_remaining_time_scheduler_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor: both channels sampled on the rising edge with pre-edge values;
  // the result is checked before the same-edge input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_report(out_data);
      if (in_valid === 1'b1 && in_stall === 1'b0)
        sb.note_request(in_data);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stall pattern: a randomly chosen mode held for a random stretch
  always @(posedge clk) begin
    if (!rst_n || rx_free) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(3, 0));
        rx_mode_left <= $urandom_range(400, 40);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN: begin
          out_stall <= 1'b0;
        end
        RX_COIN: begin
          out_stall <= 1'($urandom_range(1, 0));
        end
        RX_RARE: begin
          out_stall <= ($urandom_range(7, 0) == 0);
        end
        default: begin
          // alternating stall and pass runs of random length
          if (rx_run_left == 0) begin
            out_stall   <= !out_stall;
            rx_run_left <= $urandom_range(30, 1);
          end else begin
            rx_run_left <= rx_run_left - 1;
          end
        end
      endcase
    end
  end

  // watchdog: too long with no beat on either channel
  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic lrts_pkg::in_item_t load_item(logic [4:0] slot, logic [15:0] arr,
                                                   logic [15:0] len);
    lrts_pkg::in_item_t it;
    it.operation    = lrts_pkg::OP_LOAD;
    it.task_id      = slot;
    it.arrival_time = arr;
    it.burst_length = len;
    return it;
  endfunction

  // tick beat; the other fields are ignored, so they carry noise
  function automatic lrts_pkg::in_item_t tick_item();
    lrts_pkg::in_item_t it;
    it.operation    = lrts_pkg::OP_TICK;
    it.task_id      = 5'($urandom);
    it.arrival_time = 16'($urandom);
    it.burst_length = 16'($urandom);
    return it;
  endfunction

  // present one beat and hold it until taken; then maybe a sender gap
  task automatic send_beat(input lrts_pkg::in_item_t item);
    int unsigned gap;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (sender_fast) return;
    if (beats_left > 0) begin
      beats_left--;
    end else begin
      beats_left = $urandom_range(30, 1);
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender holds off until every expected result beat has arrived
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned pick;
    logic [15:0] arr;
    logic [15:0] len;
    int          leftover;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick on an empty table
    send_beat(tick_item());
    // zero burst on an empty slot is refused
    send_beat(load_item(5'd3, 16'h1234, 16'h0000));
    // largest slot, arrival and burst: never becomes ready
    send_beat(load_item(5'd31, 16'hFFFF, 16'hFFFF));
    send_beat(load_item(5'd0, 16'd0, 16'd2));
    send_beat(load_item(5'd5, 16'd0, 16'd2));
    // same remaining, later arrival loses the tie
    send_beat(load_item(5'd9, 16'd1, 16'd2));
    // arrives in the future
    send_beat(load_item(5'd12, 16'd3, 16'd5));
    // zero burst on a loaded slot leaves it as it was
    send_beat(load_item(5'd0, 16'd7, 16'd0));
    // full tie on remaining and arrival goes to the lower slot
    send_beat(tick_item());
    send_beat(tick_item());
    send_beat(tick_item());
    // reload of a slot that already ran restarts its remaining time
    send_beat(load_item(5'd5, 16'd2, 16'd4));
    // run everything out, then finished tasks stay idle
    repeat (13) send_beat(tick_item());
    pause_until_drained();

    // random: mostly near-term loads and ticks, with refused and far-off loads as noise
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 250 == 249)
        pause_until_drained();
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        send_beat(tick_item());
      end else if (pick < 59) begin
        send_beat(load_item(5'($urandom), 16'($urandom), 16'h0000));
      end else if (pick < 66) begin
        // full-range fields; a long burst arrives late so it cannot hog the run
        arr = 16'($urandom);
        len = 16'($urandom);
        if (len > 16'd64)
          arr[15] = 1'b1;
        send_beat(load_item(5'($urandom), arr, len));
      end else begin
        arr = sb.now + 16'($urandom_range(6, 0));
        if ($urandom_range(1, 0) == 0)
          arr = (sb.now > 16'd4) ? sb.now - 16'($urandom_range(4, 0)) : 16'd0;
        len = 16'($urandom_range(12, 1));
        send_beat(load_item(5'($urandom), arr, len));
      end
    end
    pause_until_drained();

    // short full-rate stretch: no sender gaps and an open receiver
    sender_fast = 1'b1;
    rx_free     = 1'b1;
    repeat (FAST_BEATS) begin
      if ($urandom_range(3, 0) == 0)
        send_beat(load_item(5'($urandom), sb.now + 16'($urandom_range(8, 0)),
                            16'($urandom_range(12, 1))));
      else
        send_beat(tick_item());
    end
    sender_fast = 1'b0;
    rx_free     = 1'b0;

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    leftover = sb.pending.size();
    if (leftover != 0)
      $display("%0d expected result beats never arrived", leftover);

    $display("covered %0d loads (%0d refused) and %0d ticks: %0d runs, %0d completions,",
             sb.loads, sb.refused, sb.ticks, sb.ran, sb.completions);
    $display("%0d idle ticks, %0d ticks at saturated time; %0d mismatching result beats",
             sb.idle_ticks, sb.saturated, sb.mismatches);
    if (sb.mismatches == 0 && leftover == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- longest_remaining_time_scheduler_top.f -----
hw/rtl/lrts_pkg.sv
hw/rtl/lrts_ctrl.sv
hw/rtl/lrts_dpath.sv
hw/rtl/longest_remaining_time_scheduler_top.sv
verif/tb_longest_remaining_time_scheduler_top.sv
